[src/vpli_pkg.sv]
`default_nettype none
// ============================================================================
// vpli_pkg
// Shared types, request codes and constants of the video port block.
// ============================================================================
package vpli_pkg;

  localparam int VIDEO_DEPTH_DEF     = 16384;
  localparam int LINES_PER_FRAME_DEF = 280;
  localparam int PALETTE_DEPTH_DEF   = 64;

  localparam logic [2:0] REQ_RD_DATA   = 3'd0;
  localparam logic [2:0] REQ_RD_STATUS = 3'd1;
  localparam logic [2:0] REQ_RD_LINE   = 3'd2;
  localparam logic [2:0] REQ_WR_DATA   = 3'd3;
  localparam logic [2:0] REQ_WR_CTRL   = 3'd4;
  localparam logic [2:0] REQ_TICK      = 3'd5;

  localparam logic CFG_HANDHELD = 1'b0;
  localparam logic CFG_DELAYED  = 1'b1;

  localparam logic [13:0] VADDR_MASK   = 14'h3FFF;
  localparam logic [8:0]  LINE_VBLANK  = 9'd192;
  localparam logic [8:0]  LINE_ACTIVE  = 9'd193;
  localparam logic [8:0]  LINE_IRQ_END = 9'd224;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] wr_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       irq;
    logic       color_valid;
    logic [4:0] color_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rsp_t;

endpackage
`default_nettype wire

[src/vpli_ram.sv]
`default_nettype none
// ============================================================================
// vpli_ram
// Generic single-port RAM with registered read.
// ============================================================================
module vpli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[src/vpli_fifo.sv]
`default_nettype none
// ============================================================================
// vpli_fifo
// Two-entry request queue between the front and the back.
// ============================================================================
module vpli_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire vpli_pkg::req_t din,
  output logic               full,
  input  wire logic          pop,
  output vpli_pkg::req_t     dout,
  output logic               empty
);
  vpli_pkg::req_t slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slot[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wp] <= din;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      count <= count + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) full |-> count == 2'd2;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue count");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue overrun");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && !empty)) |=> count == $past(count) + 2'd1)
    else $error("queue push lost");
endmodule
`default_nettype wire

[src/vpli_core.sv]
`default_nettype none
// ============================================================================
// vpli_core
// Back end: executes requests, owns memories and state, registers a result.
// ============================================================================
module vpli_core #(
  parameter int VIDEO_DEPTH     = vpli_pkg::VIDEO_DEPTH_DEF,
  parameter int LINES_PER_FRAME = vpli_pkg::LINES_PER_FRAME_DEF,
  parameter int PALETTE_DEPTH   = vpli_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           handheld_mode,
  input  wire logic           delayed_read,
  input  wire logic           req_valid,
  input  wire vpli_pkg::req_t req,
  output logic                req_take,
  output logic                empty,
  input  wire logic           pop,
  output vpli_pkg::rsp_t      rsp
);
  localparam int VAW = $clog2(VIDEO_DEPTH);
  localparam int PAW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] LAST_LINE = 9'(LINES_PER_FRAME - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_PAL2 = 2'd2;

  logic [1:0]  state;
  logic [7:0]  chip_registers [16];
  logic [13:0] video_address;
  logic [5:0]  palette_address;
  logic [7:0]  address_latch;
  logic        awaiting_first_byte;
  logic        target_is_video;
  logic        read_hold;
  logic [7:0]  status_flags;
  logic [8:0]  line_count;
  logic [7:0]  lines_left;
  logic        vblank_pending;
  logic        out_full;
  logic        cur_video;
  logic [7:0]  first_byte;
  logic [4:0]  cur_index;

  // memory ports
  logic           v_we;
  logic [VAW-1:0] v_addr;
  logic [7:0]     v_rdata;
  logic           p_we;
  logic [PAW-1:0] p_addr;
  logic [7:0]     p_wdata;
  logic [7:0]     p_rdata;
  logic [5:0]     pal_mask;

  assign pal_mask = handheld_mode ? 6'h3F : 6'h1F;
  assign empty    = !out_full;
  // take a new request only from idle, and only when the result slot frees up
  assign req_take = req_valid && state == ST_IDLE && (!out_full || pop);

  logic is_wr_data;
  assign is_wr_data = req.req_type == vpli_pkg::REQ_WR_DATA;

  always_comb begin
    v_we    = req_take && is_wr_data && target_is_video;
    v_addr  = VAW'(video_address);
    p_we    = 1'b0;
    p_addr  = PAW'(palette_address);
    p_wdata = req.wr_byte;
    if (state == ST_PAL2) begin
      // handheld pair: the byte lands once its partner has been fetched
      p_we    = 1'b1;
      p_wdata = first_byte;
    end else if (req_take && is_wr_data && !target_is_video) begin
      if (handheld_mode) p_addr = PAW'(palette_address ^ 6'd1);
      else p_we = 1'b1;
    end
  end

  vpli_ram #(.WIDTH(8), .DEPTH(VIDEO_DEPTH)) u_vram (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(req.wr_byte), .rdata(v_rdata)
  );
  vpli_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_pram (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
  );

  // line tick next values
  logic [8:0] lc_next;
  logic [7:0] ll_next;
  logic [7:0] sf_tick;
  logic       vb_next;
  logic       tick_irq;

  always_comb begin
    lc_next  = (line_count == LAST_LINE) ? 9'd0 : line_count + 9'd1;
    ll_next  = lines_left;
    sf_tick  = status_flags;
    vb_next  = vblank_pending;
    tick_irq = 1'b0;
    if (lc_next >= vpli_pkg::LINE_ACTIVE) begin
      if (lc_next < vpli_pkg::LINE_IRQ_END && status_flags[7] &&
          chip_registers[1][5] && awaiting_first_byte) begin
        tick_irq = 1'b1;
      end
    end else begin
      if (lc_next == vpli_pkg::LINE_VBLANK) vb_next = 1'b1;
      if (lc_next == 9'd0) ll_next = chip_registers[10];
      if (ll_next != 8'd0) begin
        ll_next = ll_next - 8'd1;
      end else begin
        ll_next    = chip_registers[10];
        sf_tick[6] = 1'b1;
      end
      if (sf_tick[6] && chip_registers[0][4]) tick_irq = 1'b1;
    end
    if (!tick_irq && vb_next) begin
      vb_next    = 1'b0;
      sf_tick[7] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      out_full            <= 1'b0;
      rsp                 <= '0;
      for (int i = 0; i < 16; i++) chip_registers[i] <= 8'h00;
      chip_registers[1]   <= 8'h60;
      chip_registers[2]   <= 8'h0E;
      chip_registers[5]   <= 8'h7F;
      chip_registers[10]  <= 8'hFF;
      video_address       <= '0;
      palette_address     <= '0;
      address_latch       <= '0;
      awaiting_first_byte <= 1'b1;
      target_is_video     <= 1'b1;
      read_hold           <= 1'b1;
      status_flags        <= '0;
      line_count          <= '0;
      lines_left          <= 8'hFF;
      vblank_pending      <= 1'b0;
      cur_video           <= 1'b0;
      first_byte          <= '0;
      cur_index           <= '0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            rsp <= '0;
            case (req.req_type)
              vpli_pkg::REQ_RD_DATA: begin
                state     <= ST_RD;
                cur_video <= target_is_video;
                if (target_is_video) begin
                  if (read_hold && delayed_read) read_hold <= 1'b0;
                  else video_address <= (video_address + 14'd1) & vpli_pkg::VADDR_MASK;
                end else begin
                  palette_address <= (palette_address + 6'd1) & pal_mask;
                end
              end
              vpli_pkg::REQ_RD_STATUS: begin
                rsp.rd_byte  <= status_flags;
                status_flags <= status_flags & 8'h3F;
                out_full     <= 1'b1;
              end
              vpli_pkg::REQ_RD_LINE: begin
                rsp.rd_byte <= line_count[8] ? 8'hFF : line_count[7:0];
                out_full    <= 1'b1;
              end
              vpli_pkg::REQ_WR_DATA: begin
                awaiting_first_byte <= 1'b1;
                if (target_is_video) begin
                  video_address <= (video_address + 14'd1) & vpli_pkg::VADDR_MASK;
                  read_hold     <= 1'b0;
                  out_full      <= 1'b1;
                end else if (handheld_mode) begin
                  // partner byte is read first, the write follows next cycle
                  state      <= ST_PAL2;
                  first_byte <= req.wr_byte;
                  cur_index  <= palette_address[5:1];
                end else begin
                  rsp.color_valid <= 1'b1;
                  rsp.color_index <= palette_address[4:0];
                  rsp.red         <= {req.wr_byte[1:0], 6'd0};
                  rsp.green       <= {req.wr_byte[3:2], 6'd0};
                  rsp.blue        <= {req.wr_byte[5:4], 6'd0};
                  palette_address <= (palette_address + 6'd1) & 6'h1F;
                  out_full        <= 1'b1;
                end
              end
              vpli_pkg::REQ_WR_CTRL: begin
                out_full <= 1'b1;
                if (awaiting_first_byte) begin
                  address_latch       <= req.wr_byte;
                  awaiting_first_byte <= 1'b0;
                end else begin
                  awaiting_first_byte <= 1'b1;
                  if (req.wr_byte[7:6] == 2'b11) begin
                    palette_address <= address_latch[5:0] & pal_mask;
                    target_is_video <= 1'b0;
                  end else if (req.wr_byte[7:6] == 2'b10) begin
                    chip_registers[req.wr_byte[3:0]] <= address_latch;
                  end else begin
                    video_address   <= {req.wr_byte[5:0], address_latch};
                    target_is_video <= 1'b1;
                    read_hold       <= req.wr_byte[6];
                  end
                end
              end
              vpli_pkg::REQ_TICK: begin
                line_count     <= lc_next;
                lines_left     <= ll_next;
                status_flags   <= sf_tick;
                vblank_pending <= vb_next;
                rsp.irq        <= tick_irq;
                out_full       <= 1'b1;
              end
              default: out_full <= 1'b1;
            endcase
          end
        end
        ST_RD: begin
          rsp.rd_byte <= cur_video ? v_rdata : p_rdata;
          out_full    <= 1'b1;
          state       <= ST_IDLE;
        end
        ST_PAL2: begin
          // p_rdata holds the partner byte of the pair
          rsp.color_valid <= 1'b1;
          rsp.color_index <= cur_index;
          if (palette_address[0]) begin
            rsp.red   <= {p_rdata[3:1], 5'd0};
            rsp.green <= {p_rdata[7:5], 5'd0};
            rsp.blue  <= {first_byte[3:1], 5'd0};
          end else begin
            rsp.red   <= {first_byte[3:1], 5'd0};
            rsp.green <= {first_byte[7:5], 5'd0};
            rsp.blue  <= {p_rdata[3:1], 5'd0};
          end
          palette_address <= (palette_address + 6'd1) & 6'h3F;
          out_full        <= 1'b1;
          state           <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    req_take |-> state == ST_IDLE) else $error("take outside idle");
  a_rd_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |=> out_full && state == ST_IDLE) else $error("read lost");
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (out_full && !pop) |=> out_full) else $error("result dropped");
endmodule
`default_nettype wire

[src/video_port_and_line_interrupt.sv]
`default_nettype none
// ============================================================================
// video_port_and_line_interrupt
// Video chip CPU-port interface with palette output and line interrupt.
// ============================================================================
// Requests enter a two-entry queue and are executed in order by the back end,
// which owns video memory, palette memory and chip registers; each request
// yields one result in a one-entry result register. Most requests finish
// from the idle state; data reads and handheld palette writes also pass
// through ST_RD or ST_PAL2, set by the registered read port of the memory.
// After reset the block is ready at once; memories are not cleared.
module video_port_and_line_interrupt #(
  parameter int VIDEO_DEPTH     = vpli_pkg::VIDEO_DEPTH_DEF,
  parameter int LINES_PER_FRAME = vpli_pkg::LINES_PER_FRAME_DEF,
  parameter int PALETTE_DEPTH   = vpli_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire vpli_pkg::req_t req,
  output logic                empty,
  input  wire logic           pop,
  output vpli_pkg::rsp_t      rsp,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic           cfg_data
);
  logic           handheld_mode;
  logic           delayed_read;
  logic           q_empty;
  logic           q_pop;
  vpli_pkg::req_t q_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      handheld_mode <= 1'b0;
      delayed_read  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == vpli_pkg::CFG_HANDHELD) handheld_mode <= cfg_data;
      if (cfg_index == vpli_pkg::CFG_DELAYED)  delayed_read  <= cfg_data;
    end
  end

  vpli_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .din(req), .full(full),
    .pop(q_pop), .dout(q_req), .empty(q_empty)
  );

  vpli_core #(
    .VIDEO_DEPTH(VIDEO_DEPTH), .LINES_PER_FRAME(LINES_PER_FRAME),
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_core (
    .clk(clk), .rst(rst), .handheld_mode(handheld_mode), .delayed_read(delayed_read),
    .req_valid(!q_empty), .req(q_req), .req_take(q_pop),
    .empty(empty), .pop(pop), .rsp(rsp)
  );
endmodule
`default_nettype wire
